// ===== sv/char_lcd_4bit_interface_assert.svh =====
// Assertion helpers for the LCD interface modules (used by lcd4_back).
// Each expects signals named clk and rst in the using module.
`ifndef CHAR_LCD_4BIT_INTERFACE_ASSERT_SVH
`define CHAR_LCD_4BIT_INTERFACE_ASSERT_SVH

// Same-cycle implication, off during reset.
`define LCD4_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define LCD4_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/lcd4_pkg.sv =====
package lcd4_pkg;

  // Request codes
  typedef enum logic [2:0] {
    CMD_INIT   = 3'd0,
    CMD_BYTE   = 3'd1,
    CMD_DATA   = 3'd2,
    CMD_CURSOR = 3'd3,
    CMD_MODE   = 3'd4,
    CMD_GLYPH  = 3'd5
  } cmd_code_t;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_COMMAND_WAIT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STROBE_HALF  = 1'd1;
  localparam logic [15:0] COMMAND_WAIT_RESET = 16'd40;
  localparam logic [7:0]  STROBE_HALF_RESET  = 8'd1;

  // Fixed init waits, microseconds
  localparam logic [15:0] WAKE_WAIT_US  = 16'd20000;
  localparam logic [15:0] LONG_WAIT_US  = 16'd5000;
  localparam logic [15:0] SHORT_WAIT_US = 16'd100;

  // Controller command bytes
  localparam logic [7:0] DDRAM_SET     = 8'h80;
  localparam logic [7:0] CGRAM_SET     = 8'h40;
  localparam logic [7:0] FUNC_SET_4BIT = 8'h20;
  localparam logic [7:0] DISP_OFF      = 8'h08;
  localparam logic [7:0] DISP_ON       = 8'h0C;
  localparam logic [7:0] DISP_CURSOR   = 8'h0E;
  localparam logic [7:0] DISP_BLINK    = 8'h0F;
  localparam logic [7:0] CLEAR_DISP    = 8'h01;
  localparam logic [7:0] ENTRY_MODE    = 8'h06;
  localparam logic [3:0] WAKE_NIBBLE   = 4'h3;
  localparam logic [3:0] BUS4_NIBBLE   = 4'h2;
  localparam logic [2:0] GLYPH_MAX     = 3'd7;

  // Phase sequencing
  localparam int PHASE_IDX_W = 6;
  localparam logic [PHASE_IDX_W-1:0] BYTE_LAST = 6'd4;
  localparam logic [PHASE_IDX_W-1:0] INIT_LAST = 6'd43;

  // Request queue
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_HI   = 2'd1,
    PH_LO   = 2'd2
  } phase_kind_t;

  typedef enum logic [2:0] {
    HOLD_CMD    = 3'd0,
    HOLD_STROBE = 3'd1,
    HOLD_WAKE   = 3'd2,
    HOLD_LONG   = 3'd3,
    HOLD_SHORT  = 3'd4
  } hold_sel_t;

  typedef struct packed {
    phase_kind_t kind;
    logic [3:0]  nib;
    hold_sel_t   hold;
  } phase_desc_t;

  // One classified request: init sequence or a single byte write
  typedef struct packed {
    logic       is_init;
    logic       rs;
    logic [7:0] data;
  } job_t;

  function automatic phase_desc_t mk_phase(input phase_kind_t kind, input logic [3:0] nib,
                                           input hold_sel_t hold);
    phase_desc_t d;
    d.kind = kind;
    d.nib  = nib;
    d.hold = hold;
    return d;
  endfunction

  // Byte write: wait, high nibble strobe, low nibble strobe
  function automatic phase_desc_t byte_phase(input logic [7:0] b, input logic [2:0] sub);
    phase_desc_t d;
    case (sub)
      3'd0:    d = mk_phase(PH_WAIT, 4'h0, HOLD_CMD);
      3'd1:    d = mk_phase(PH_HI, b[7:4], HOLD_STROBE);
      3'd2:    d = mk_phase(PH_LO, b[7:4], HOLD_STROBE);
      3'd3:    d = mk_phase(PH_HI, b[3:0], HOLD_STROBE);
      default: d = mk_phase(PH_LO, b[3:0], HOLD_STROBE);
    endcase
    return d;
  endfunction

  // Power-on wake sequence followed by six command bytes
  function automatic phase_desc_t init_phase(input logic [PHASE_IDX_W-1:0] idx);
    phase_desc_t d;
    case (idx) inside
      6'd0:            d = mk_phase(PH_WAIT, 4'h0, HOLD_WAKE);
      6'd1, 6'd4, 6'd7, 6'd10:
                       d = mk_phase(PH_HI, WAKE_NIBBLE, HOLD_STROBE);
      6'd2, 6'd5, 6'd8, 6'd11:
                       d = mk_phase(PH_LO, WAKE_NIBBLE, HOLD_STROBE);
      6'd3, 6'd9:      d = mk_phase(PH_WAIT, 4'h0, HOLD_LONG);
      6'd6:            d = mk_phase(PH_WAIT, 4'h0, HOLD_SHORT);
      6'd12:           d = mk_phase(PH_HI, BUS4_NIBBLE, HOLD_STROBE);
      6'd13:           d = mk_phase(PH_LO, BUS4_NIBBLE, HOLD_STROBE);
      [6'd14:6'd18]:   d = byte_phase(FUNC_SET_4BIT, 3'(idx - 6'd14));
      [6'd19:6'd23]:   d = byte_phase(DISP_OFF, 3'(idx - 6'd19));
      [6'd24:6'd28]:   d = byte_phase(CLEAR_DISP, 3'(idx - 6'd24));
      [6'd29:6'd33]:   d = byte_phase(ENTRY_MODE, 3'(idx - 6'd29));
      [6'd34:6'd38]:   d = byte_phase(DISP_ON, 3'(idx - 6'd34));
      default:         d = byte_phase(CLEAR_DISP, 3'(idx - 6'd39));
    endcase
    return d;
  endfunction

  function automatic logic [7:0] mode_cmd(input logic [1:0] mode);
    logic [7:0] c;
    case (mode)
      2'd0:    c = DISP_OFF;
      2'd1:    c = DISP_ON;
      2'd2:    c = DISP_CURSOR;
      default: c = DISP_BLINK;
    endcase
    return c;
  endfunction

endpackage

// ===== sv/lcd4_if.sv =====
// Request channel: one LCD operation
interface lcd4_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] value;
  logic [7:0] row;

  modport source(output valid, command, value, row, input ready);
  modport sink(input valid, command, value, row, output ready);
endinterface

// Phase channel: pin levels and their hold time
interface lcd4_phase_if;
  logic        valid;
  logic        ready;
  logic        reg_select;
  logic        read_write;
  logic        enable;
  logic [3:0]  nibble;
  logic [15:0] hold_us;
  logic        last;

  modport source(output valid, reg_select, read_write, enable, nibble, hold_us, last,
                 input ready);
  modport sink(input valid, reg_select, read_write, enable, nibble, hold_us, last,
               output ready);
endinterface

// ===== sv/lcd4_front.sv =====
module lcd4_front
  import lcd4_pkg::*;
#(
  parameter int COLUMNS = 16,
  parameter int ROWS    = 2
) (
  lcd4_req_if.sink req,
  output logic     push_valid,
  input  logic     push_ready,
  output job_t     push_job
);

  logic       has_phase;
  logic [7:0] col_c;
  logic [1:0] row_c;
  logic [2:0] glyph;

  // Zero an out-of-range cursor column or row; clamp the glyph index
  always_comb begin
    col_c = (req.value >= 8'(COLUMNS)) ? 8'd0 : req.value;
    row_c = (req.row >= 8'(ROWS)) ? 2'd0 : req.row[1:0];
    glyph = (req.value > 8'(GLYPH_MAX)) ? GLYPH_MAX : req.value[2:0];
  end

  // Classify request into an init job or a byte write
  always_comb begin
    has_phase        = 1'b1;
    push_job.is_init = 1'b0;
    push_job.rs      = 1'b0;
    push_job.data    = req.value;
    case (req.command)
      CMD_INIT: begin
        push_job.is_init = 1'b1;
      end
      CMD_BYTE: begin
      end
      CMD_DATA: begin
        push_job.rs = 1'b1;
      end
      CMD_CURSOR: begin
        push_job.data = DDRAM_SET | {row_c, 6'b0} | col_c;
      end
      CMD_MODE: begin
        has_phase     = (req.value < 8'd4);
        push_job.data = mode_cmd(req.value[1:0]);
      end
      CMD_GLYPH: begin
        push_job.data = CGRAM_SET | {2'b0, glyph, 3'b0};
      end
      default: begin
        has_phase = 1'b0;
      end
    endcase
  end

  // Drop requests that cause no phases; otherwise queue them
  assign req.ready  = push_ready;
  assign push_valid = req.valid && has_phase;

endmodule

// ===== sv/lcd4_queue.sv =====
module lcd4_queue
  import lcd4_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_job
);

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign push_ready = (count != QCNT_W'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_job    = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/lcd4_back.sv =====
`include "char_lcd_4bit_interface_assert.svh"

module lcd4_back
  import lcd4_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic [15:0]   command_wait_us,
  input  logic [7:0]    strobe_half_us,
  input  logic          q_valid,
  output logic          q_ready,
  input  job_t          q_job,
  lcd4_phase_if.source  phase
);

  logic [PHASE_IDX_W-1:0] idx;
  logic                   out_valid;
  logic                   out_rs;
  logic                   out_en;
  logic [3:0]             out_nib;
  logic [15:0]            out_hold;
  logic                   out_last;
  logic                   driven_rs;
  logic [3:0]             driven_nibble;

  phase_desc_t            desc;
  logic                   is_last;
  logic                   advance;
  logic                   ph_rs;
  logic [3:0]             ph_nib;
  logic [15:0]            ph_hold;

  // Decode the current phase of the head request
  always_comb begin
    desc    = q_job.is_init ? init_phase(idx) : byte_phase(q_job.data, idx[2:0]);
    is_last = q_job.is_init ? (idx == INIT_LAST) : (idx == BYTE_LAST);
    ph_rs   = (desc.kind == PH_WAIT) ? driven_rs : q_job.rs;
    ph_nib  = (desc.kind == PH_WAIT) ? driven_nibble : desc.nib;
    case (desc.hold)
      HOLD_CMD:    ph_hold = command_wait_us;
      HOLD_STROBE: ph_hold = {8'b0, strobe_half_us};
      HOLD_WAKE:   ph_hold = WAKE_WAIT_US;
      HOLD_LONG:   ph_hold = LONG_WAIT_US;
      HOLD_SHORT:  ph_hold = SHORT_WAIT_US;
      default:     ph_hold = command_wait_us;
    endcase
  end

  // Emit one phase whenever the output register frees up
  assign advance = q_valid && (!out_valid || phase.ready);
  assign q_ready = advance && is_last;

  // Sequencer and bus level tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      idx           <= '0;
      out_valid     <= 1'b0;
      driven_rs     <= 1'b0;
      driven_nibble <= 4'h0;
    end else begin
      if (advance) begin
        idx           <= is_last ? '0 : idx + 1'b1;
        out_valid     <= 1'b1;
        driven_rs     <= ph_rs;
        driven_nibble <= ph_nib;
      end else if (phase.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (advance) begin
      out_rs   <= ph_rs;
      out_en   <= (desc.kind == PH_HI);
      out_nib  <= ph_nib;
      out_hold <= ph_hold;
      out_last <= is_last;
    end
  end

  assign phase.valid      = out_valid;
  assign phase.reg_select = out_rs;
  assign phase.read_write = 1'b0;
  assign phase.enable     = out_en;
  assign phase.nibble     = out_nib;
  assign phase.hold_us    = out_hold;
  assign phase.last       = out_last;

  // A request in progress stays at the queue head until its last phase
  `LCD4_ASSERT(a_head_held, idx != '0, q_valid, "sequencer mid-request with empty queue")
  // Byte writes never run past their fifth phase
  `LCD4_ASSERT(a_byte_bound, q_valid && !q_job.is_init, idx <= BYTE_LAST,
               "byte write phase index out of range")
  // Releasing a request coincides with loading its final phase
  `LCD4_ASSERT_NEXT(a_pop_last, q_valid && q_ready, out_valid && out_last,
                    "request released without final phase marked")

endmodule

// ===== sv/char_lcd_4bit_interface.sv =====
// Character LCD driver for the 4-bit bus, write only.
// req channel: one operation per request (init, command byte, data byte,
//   set cursor, display mode, glyph select). Display mode values above 3 and
//   unused command codes are taken and dropped without output.
// phase channel: one item per pin phase (RS, RW, E, D7..D4, hold time in us);
//   last marks the final phase of a request.
// A byte write gives 5 phases and init gives 44, one phase per cycle while the
//   receiver keeps up; the phase sequencer sets this rate. A taken request is
//   held in the queue, and each phase is registered before it is presented.
// A two-entry request queue sits between classification and the sequencer, so
//   requests are taken while earlier ones still play out.
// Config writes (cfg_we, cfg_index, cfg_wdata) are taken every cycle; write
//   them only while the block is idle. Index 0 is the wait before each byte,
//   index 1 the enable half period.
// Reset clears the queue, the sequencer and the tracked RS/data levels, and
//   loads the default timings (40 us, 1 us).
// When the receiver stalls, the current phase holds on the output and the
//   sequencer waits; the queue fills and then req.ready drops.
module char_lcd_4bit_interface
  import lcd4_pkg::*;
#(
  parameter int COLUMNS = 16,
  parameter int ROWS    = 2
) (
  input  logic                   clk,
  input  logic                   rst,
  lcd4_req_if.sink               req,
  lcd4_phase_if.source           phase,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]            cfg_wdata
);

  logic [15:0] command_wait_us;
  logic [7:0]  strobe_half_us;

  logic        push_valid;
  logic        push_ready;
  job_t        push_job;
  logic        pop_valid;
  logic        pop_ready;
  job_t        pop_job;

  // Timing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      command_wait_us <= COMMAND_WAIT_RESET;
      strobe_half_us  <= STROBE_HALF_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COMMAND_WAIT: command_wait_us <= cfg_wdata;
        REG_STROBE_HALF:  strobe_half_us  <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  lcd4_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .req        (req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  lcd4_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  lcd4_back u_back (
    .clk             (clk),
    .rst             (rst),
    .command_wait_us (command_wait_us),
    .strobe_half_us  (strobe_half_us),
    .q_valid         (pop_valid),
    .q_ready         (pop_ready),
    .q_job           (pop_job),
    .phase           (phase)
  );

endmodule
